// File: rtl/quad_face_normal_orient_top_macros.svh
// quad_face_normal_orient_top_macros.svh: assertion macros for the face normal checker.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef QUAD_FACE_NORMAL_ORIENT_TOP_MACROS_SVH
`define QUAD_FACE_NORMAL_ORIENT_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define QFNO_AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define QFNO_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define QFNO_AST_NEXT_ALL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/qfno_pkg.sv
// qfno_pkg: shared widths, codes and types of the quad face normal block.
// No dependencies.
`default_nettype none
package qfno_pkg;
    localparam int COORD_W   = 16;
    localparam int NORM_FRAC = 14;
    localparam int NORM_W    = NORM_FRAC + 2;
    localparam int A_W       = COORD_W + 4;   // dx or spherical raw vector
    localparam int B_W       = COORD_W + 2;   // dy
    localparam int D_W       = COORD_W + 1;   // orientation reference
    localparam int RAW_W     = 37;            // cross product component

    localparam logic [1:0] CORNER_LAST = 2'd3;

    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_SPH   = 3'd1;
    localparam logic [2:0] MODE_EXT   = 3'd2;
    localparam logic [2:0] MODE_DIR   = 3'd3;
    localparam logic [2:0] MODE_PREV  = 3'd4;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_REF_X = 2'd1;
    localparam logic [1:0] REG_REF_Y = 2'd2;
    localparam logic [1:0] REG_REF_Z = 2'd3;

    typedef struct packed {
        logic [2:0]                mode;
        logic signed [COORD_W-1:0] ref_x;
        logic signed [COORD_W-1:0] ref_y;
        logic signed [COORD_W-1:0] ref_z;
    } t_cfg;

    // one face worth of work for the back end
    typedef struct packed {
        logic                  sph;
        logic                  flip;
        logic signed [A_W-1:0] a0;
        logic signed [A_W-1:0] a1;
        logic signed [A_W-1:0] a2;
        logic signed [B_W-1:0] b0;
        logic signed [B_W-1:0] b1;
        logic signed [B_W-1:0] b2;
        logic signed [D_W-1:0] d0;
        logic signed [D_W-1:0] d1;
        logic signed [D_W-1:0] d2;
    } t_job;
endpackage
`default_nettype wire

// File: rtl/qfno_fifo.sv
// qfno_fifo: two-entry job queue between front and back end.
// Depends on qfno_pkg (t_job).
`default_nettype none
module qfno_fifo (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  qfno_pkg::t_job i_job,
    output logic          o_full,
    input  wire           i_pop,
    output logic          o_valid,
    output qfno_pkg::t_job o_job
);
    qfno_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

// File: rtl/qfno_front.sv
// qfno_front: corner store and per-face setup (diagonals, spherical vector, flip reference).
// Depends on qfno_pkg.
`default_nettype none
module qfno_front (
    input  wire                           i_clk,
    input  wire                           i_acc,
    input  wire [1:0]                     i_corner,
    input  wire signed [qfno_pkg::COORD_W-1:0] i_x,
    input  wire signed [qfno_pkg::COORD_W-1:0] i_y,
    input  wire signed [qfno_pkg::COORD_W-1:0] i_z,
    input  wire signed [qfno_pkg::NORM_W-1:0]  i_onx,
    input  wire signed [qfno_pkg::NORM_W-1:0]  i_ony,
    input  wire signed [qfno_pkg::NORM_W-1:0]  i_onz,
    input  qfno_pkg::t_cfg                i_cfg,
    output logic                          o_push,
    output qfno_pkg::t_job                o_job
);
    localparam int CW = qfno_pkg::COORD_W;
    localparam int AW = qfno_pkg::A_W;
    localparam int DW = qfno_pkg::D_W;

    logic signed [CW-1:0] r_px [3];
    logic signed [CW-1:0] r_py [3];
    logic signed [CW-1:0] r_pz [3];

    // one axis: P1..P3 from store, P4 from input
    function automatic logic signed [AW-1:0] f_dx(input logic signed [CW-1:0] p1, p2, p3, p4);
        f_dx = AW'(p2) - AW'(p1) + AW'(p3) - AW'(p4);
    endfunction
    function automatic logic signed [AW-1:0] f_dy(input logic signed [CW-1:0] p1, p2, p3, p4);
        f_dy = AW'(p4) - AW'(p1) + AW'(p3) - AW'(p2);
    endfunction
    function automatic logic signed [AW-1:0] f_sph(input logic signed [CW-1:0] p1, p2, p3, p4,
                                                   input logic signed [CW-1:0] rf);
        f_sph = AW'(p1) + AW'(p2) + AW'(p3) + AW'(p4) - (AW'(rf) <<< 2);
    endfunction

    logic [2:0] w_mode;
    logic signed [AW-1:0] w_dx0, w_dx1, w_dx2, w_dy0, w_dy1, w_dy2;

    always_comb begin
        w_mode = (i_cfg.mode > qfno_pkg::MODE_PREV) ? qfno_pkg::MODE_PLAIN : i_cfg.mode;
        w_dx0 = f_dx(r_px[0], r_px[1], r_px[2], i_x);
        w_dx1 = f_dx(r_py[0], r_py[1], r_py[2], i_y);
        w_dx2 = f_dx(r_pz[0], r_pz[1], r_pz[2], i_z);
        w_dy0 = f_dy(r_px[0], r_px[1], r_px[2], i_x);
        w_dy1 = f_dy(r_py[0], r_py[1], r_py[2], i_y);
        w_dy2 = f_dy(r_pz[0], r_pz[1], r_pz[2], i_z);

        o_job.sph  = (w_mode == qfno_pkg::MODE_SPH);
        o_job.flip = (w_mode == qfno_pkg::MODE_EXT) || (w_mode == qfno_pkg::MODE_DIR) ||
                     (w_mode == qfno_pkg::MODE_PREV);
        if (o_job.sph) begin
            o_job.a0 = f_sph(r_px[0], r_px[1], r_px[2], i_x, i_cfg.ref_x);
            o_job.a1 = f_sph(r_py[0], r_py[1], r_py[2], i_y, i_cfg.ref_y);
            o_job.a2 = f_sph(r_pz[0], r_pz[1], r_pz[2], i_z, i_cfg.ref_z);
        end else begin
            o_job.a0 = w_dx0;
            o_job.a1 = w_dx1;
            o_job.a2 = w_dx2;
        end
        o_job.b0 = qfno_pkg::B_W'(w_dy0);
        o_job.b1 = qfno_pkg::B_W'(w_dy1);
        o_job.b2 = qfno_pkg::B_W'(w_dy2);

        case (w_mode)
            qfno_pkg::MODE_EXT: begin
                o_job.d0 = DW'(r_px[0]) - DW'(i_cfg.ref_x);
                o_job.d1 = DW'(r_py[0]) - DW'(i_cfg.ref_y);
                o_job.d2 = DW'(r_pz[0]) - DW'(i_cfg.ref_z);
            end
            qfno_pkg::MODE_DIR: begin
                o_job.d0 = DW'(i_cfg.ref_x);
                o_job.d1 = DW'(i_cfg.ref_y);
                o_job.d2 = DW'(i_cfg.ref_z);
            end
            default: begin
                o_job.d0 = DW'(i_onx);
                o_job.d1 = DW'(i_ony);
                o_job.d2 = DW'(i_onz);
            end
        endcase
    end

    assign o_push = i_acc && (i_corner == qfno_pkg::CORNER_LAST);

    always_ff @(posedge i_clk) begin
        if (i_acc && (i_corner != qfno_pkg::CORNER_LAST)) begin
            r_px[i_corner] <= i_x;
            r_py[i_corner] <= i_y;
            r_pz[i_corner] <= i_z;
        end
    end
endmodule
`default_nettype wire

// File: rtl/qfno_back.sv
// qfno_back: cross product, normalization (shift, square root, divide) and flip.
// Depends on qfno_pkg; one shared registered 33x33 multiplier.
`default_nettype none
module qfno_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    input  qfno_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  wire            i_ready,
    output logic signed [qfno_pkg::NORM_W-1:0] o_nx,
    output logic signed [qfno_pkg::NORM_W-1:0] o_ny,
    output logic signed [qfno_pkg::NORM_W-1:0] o_nz,
    output logic           o_degen
);
    localparam int RW = qfno_pkg::RAW_W;
    localparam int NW = qfno_pkg::NORM_W;
    localparam logic [14:0] Q_CAP = 15'(1 << qfno_pkg::NORM_FRAC);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CROSS, ST_CONV, ST_SHIFT, ST_SQR, ST_SQRT, ST_DIV, ST_DOT, ST_OUT
    } t_state;

    t_state              r_state;
    qfno_pkg::t_job      r_job;
    logic [4:0]          r_step;
    logic [1:0]          r_comp;
    logic signed [RW-1:0] r_raw [3];
    logic [RW-1:0]       r_mag [3];
    logic                r_neg [3];
    logic [63:0]         r_sum, r_res, r_bit;
    logic [31:0]         r_rem;
    logic [14:0]         r_lo, r_q;
    logic signed [NW-1:0] r_nrm [3];
    logic signed [35:0]  r_dot;
    logic                r_degen;
    logic signed [65:0]  r_prod;

    logic signed [32:0]  w_ma, w_mb;
    logic [1:0]          w_idx;
    logic [RW-1:0]       w_max;
    logic [32:0]         w_t;
    logic                w_ge;
    logic [14:0]         n_q, w_qc;
    logic [45:0]         w_num;
    logic signed [35:0]  n_dot;

    assign o_pop   = (r_state == ST_IDLE) && i_valid;
    assign o_valid = (r_state == ST_OUT);
    assign o_nx    = r_nrm[0];
    assign o_ny    = r_nrm[1];
    assign o_nz    = r_nrm[2];
    assign o_degen = r_degen;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_CROSS: begin
                case (r_step)
                    5'd0: begin w_ma = 33'(r_job.a1); w_mb = 33'(r_job.b2); end
                    5'd1: begin w_ma = 33'(r_job.a2); w_mb = 33'(r_job.b1); end
                    5'd2: begin w_ma = 33'(r_job.a2); w_mb = 33'(r_job.b0); end
                    5'd3: begin w_ma = 33'(r_job.a0); w_mb = 33'(r_job.b2); end
                    5'd4: begin w_ma = 33'(r_job.a0); w_mb = 33'(r_job.b1); end
                    5'd5: begin w_ma = 33'(r_job.a1); w_mb = 33'(r_job.b0); end
                    default: ;
                endcase
            end
            ST_SQR: begin
                if (r_step < 5'd3) begin
                    w_ma = $signed({2'b00, r_mag[r_step[1:0]][30:0]});
                    w_mb = w_ma;
                end
            end
            ST_DOT: begin
                case (r_step)
                    5'd0: begin w_ma = 33'(r_nrm[0]); w_mb = 33'(r_job.d0); end
                    5'd1: begin w_ma = 33'(r_nrm[1]); w_mb = 33'(r_job.d1); end
                    5'd2: begin w_ma = 33'(r_nrm[2]); w_mb = 33'(r_job.d2); end
                    default: ;
                endcase
            end
            default: ;
        endcase

        w_idx = 2'((r_step - 5'd1) >> 1);
        w_max = r_mag[0];
        if (r_mag[1] > w_max) w_max = r_mag[1];
        if (r_mag[2] > w_max) w_max = r_mag[2];

        // restoring divide step
        w_t  = {r_rem, r_lo[14]};
        w_ge = (w_t >= {1'b0, r_res[31:0]});
        n_q  = {r_q[13:0], w_ge};
        w_qc = (n_q > Q_CAP) ? Q_CAP : n_q;
        w_num = {r_mag[r_comp][30:0], 15'b0} - 46'({r_mag[r_comp][30:0], 14'b0})
                + 46'(r_res[31:1]);
        n_dot = r_dot + 36'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_job  <= i_job;
                        r_step <= '0;
                        for (int k = 0; k < 3; k++) r_raw[k] <= '0;
                        if (i_job.sph) begin
                            r_raw[0] <= RW'(i_job.a0);
                            r_raw[1] <= RW'(i_job.a1);
                            r_raw[2] <= RW'(i_job.a2);
                            r_state  <= ST_CONV;
                        end else begin
                            r_state <= ST_CROSS;
                        end
                    end
                end
                ST_CROSS: begin
                    if (r_step != 5'd0) begin
                        if (r_step[0])
                            r_raw[w_idx] <= r_raw[w_idx] + RW'(r_prod);
                        else
                            r_raw[w_idx] <= r_raw[w_idx] - RW'(r_prod);
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd6) r_state <= ST_CONV;
                end
                ST_CONV: begin
                    for (int k = 0; k < 3; k++) begin
                        r_neg[k] <= r_raw[k][RW-1];
                        r_mag[k] <= r_raw[k][RW-1] ? RW'(-r_raw[k]) : RW'(r_raw[k]);
                    end
                    r_degen <= 1'b0;
                    if ((r_raw[0] == '0) && (r_raw[1] == '0) && (r_raw[2] == '0)) begin
                        for (int k = 0; k < 3; k++) r_nrm[k] <= '0;
                        r_degen <= 1'b1;
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    // largest magnitude into [2^30, 2^31), one bit a cycle
                    if (w_max[RW-1:31] != '0) begin
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 1;
                    end else if (!w_max[30]) begin
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 1;
                    end else begin
                        r_step  <= '0;
                        r_sum   <= '0;
                        r_state <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd3) begin
                        r_sum   <= r_sum + r_prod[63:0];
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_step  <= '0;
                        r_state <= ST_SQRT;
                    end else if (r_step != 5'd0) begin
                        r_sum <= r_sum + r_prod[63:0];
                    end
                end
                ST_SQRT: begin
                    if (r_sum >= r_res + r_bit) begin
                        r_sum <= r_sum - (r_res + r_bit);
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_step  <= '0;
                        r_comp  <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_step == 5'd0) begin
                        r_rem  <= 32'(w_num[45:15]);
                        r_lo   <= w_num[14:0];
                        r_q    <= '0;
                        r_step <= 5'd1;
                    end else begin
                        r_rem  <= w_ge ? 32'(w_t - {1'b0, r_res[31:0]}) : w_t[31:0];
                        r_lo   <= r_lo << 1;
                        r_q    <= n_q;
                        r_step <= r_step + 5'd1;
                        if (r_step == 5'd15) begin
                            r_nrm[r_comp] <= r_neg[r_comp] ? -NW'(w_qc) : NW'(w_qc);
                            r_step <= '0;
                            r_comp <= r_comp + 2'd1;
                            if (r_comp == 2'd2) begin
                                r_dot   <= '0;
                                r_state <= r_job.flip ? ST_DOT : ST_OUT;
                            end
                        end
                    end
                end
                ST_DOT: begin
                    r_step <= r_step + 5'd1;
                    if (r_step != 5'd0) r_dot <= n_dot;
                    if (r_step == 5'd3) begin
                        if (n_dot < 0) begin
                            for (int k = 0; k < 3; k++) r_nrm[k] <= -r_nrm[k];
                        end
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/quad_face_normal_orient_top.sv
// quad_face_normal_orient_top: unit normal of a quad face from four corner items.
// Depends on qfno_pkg, qfno_front, qfno_fifo, qfno_back.
//
// Usage:
//  - s_* channel: one item per corner. tdata = coord_x, coord_y, coord_z (Q8.8),
//    old_normal_x/y/z (Q1.14); tuser = corner. Corners 0..2 are stored, corner 3
//    closes the face and queues it for the back end.
//  - m_* channel: one item per face: normal_x/y/z (Q1.14) in tdata, degenerate
//    flag in tuser. A zero raw vector gives a zero normal and degenerate = 1.
//  - APB port: mode at 0x0, ref_x/y/z at 0x4/0x8/0xC; write only while idle.
// Flow: a corner is taken whenever the two-entry face queue is not full.
// The back end runs one face at a time on one shared multiplier: a load step,
// the cross product (none in spherical mode), a magnitude step, magnitude
// shifting, squares, bit-pair square root, restoring divide of each of the
// three components, dot product in the flip modes and the output step. A
// degenerate face goes from the magnitude step straight to the output.
// Reset clears the queue, the back end and the registers; stored corners are
// undefined until written. If m_tready stays low the result is held in the output
// register while the front keeps taking corners until the queue fills.
`default_nettype none
module quad_face_normal_orient_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [95:0]  s_tdata,   // coord_x, coord_y, coord_z, old_normal_x, _y, _z
    input  wire [1:0]   s_tuser,   // corner
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // normal_x, normal_y, normal_z
    output logic [0:0]  m_tuser,   // degenerate
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [3:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = qfno_pkg::COORD_W;

    qfno_pkg::t_cfg r_cfg;
    qfno_pkg::t_job w_job, w_qjob;
    logic w_push, w_full, w_qvalid, w_pop, w_acc;
    logic signed [qfno_pkg::NORM_W-1:0] w_nx, w_ny, w_nz;
    logic w_degen;

    assign pready = 1'b1;

    // config registers, register index in paddr[3:2]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                qfno_pkg::REG_MODE:  r_cfg.mode  <= pwdata[2:0];
                qfno_pkg::REG_REF_X: r_cfg.ref_x <= pwdata[CW-1:0];
                qfno_pkg::REG_REF_Y: r_cfg.ref_y <= pwdata[CW-1:0];
                qfno_pkg::REG_REF_Z: r_cfg.ref_z <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            qfno_pkg::REG_MODE:  prdata = 32'(r_cfg.mode);
            qfno_pkg::REG_REF_X: prdata = 32'(r_cfg.ref_x);
            qfno_pkg::REG_REF_Y: prdata = 32'(r_cfg.ref_y);
            qfno_pkg::REG_REF_Z: prdata = 32'(r_cfg.ref_z);
            default:             prdata = '0;
        endcase
    end

    // corners stall only while the face queue is full
    assign s_tready = !w_full;
    assign w_acc    = s_tvalid && s_tready;

    qfno_front u_front (
        .i_clk   (i_clk),
        .i_acc   (w_acc),
        .i_corner(s_tuser),
        .i_x     (s_tdata[15:0]),
        .i_y     (s_tdata[31:16]),
        .i_z     (s_tdata[47:32]),
        .i_onx   (s_tdata[63:48]),
        .i_ony   (s_tdata[79:64]),
        .i_onz   (s_tdata[95:80]),
        .i_cfg   (r_cfg),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    qfno_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_qvalid),
        .o_job  (w_qjob)
    );

    qfno_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_qvalid),
        .i_job  (w_qjob),
        .o_pop  (w_pop),
        .o_valid(m_tvalid),
        .i_ready(m_tready),
        .o_nx   (w_nx),
        .o_ny   (w_ny),
        .o_nz   (w_nz),
        .o_degen(w_degen)
    );

    assign m_tdata = {w_nz, w_ny, w_nx};
    assign m_tuser = w_degen;
endmodule
`default_nettype wire

// File: rtl/qfno_checker.sv
// qfno_checker: port-level assertions for the quad face normal block, bound to the top.
// Depends on quad_face_normal_orient_top_macros.svh.
`default_nettype none
`include "quad_face_normal_orient_top_macros.svh"
module qfno_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [95:0] s_tdata,
    input wire [1:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [47:0] m_tdata,
    input wire [0:0]  m_tuser,
    input wire        psel,
    input wire        penable,
    input wire        pwrite,
    input wire [3:0]  paddr,
    input wire [31:0] pwdata,
    input wire [31:0] prdata,
    input wire        pready
);
    `QFNO_AST_NEXT_ALL(a_rst_quiet, !i_rst_n, !m_tvalid, "result valid right after reset")
    `QFNO_AST_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `QFNO_AST_SAME(a_degen_zero, m_tvalid && m_tuser[0], m_tdata == 48'd0, "degenerate face with nonzero normal")
    `QFNO_AST_SAME(a_normal_nz, m_tvalid && !m_tuser[0], m_tdata != 48'd0, "zero normal without degenerate flag")
endmodule

bind quad_face_normal_orient_top qfno_checker u_qfno_checker (.*);
`default_nettype wire

// File: tb/sv/testbench.sv
// testbench: self-checking bench for quad_face_normal_orient_top.
// Depends on qfno_pkg and the block's RTL; predicts each face normal and checks it.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    // face normal result as it leaves the block
    typedef struct {
        logic signed [qfno_pkg::NORM_W-1:0] nx, ny, nz;
        logic                               degen;
    } t_normal;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    quad_face_normal_orient_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // predictor state: registers and stored corners
    logic [2:0]          cfg_mode;
    longint              cfg_ref[3];
    longint              corners[3][3];
    bit                  corner_seen[3];
    t_normal             pending_normals[$];
    bit                  failed = 1'b0;
    int unsigned         cycle_count = 0;
    int unsigned         gap_max = 0;   // sender burst gap ceiling
    int unsigned         stall_pct = 30;

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint trunc_shr(longint v, int s);
        return v < 0 ? -((-v) >>> s) : (v >>> s);
    endfunction

    function automatic longint floor_sqrt(longint unsigned x);
        longint unsigned res = 0, bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // sign of n.d, split so no product overflows 64 bits
    function automatic int dot_sign(longint n[3], longint d[3]);
        longint hi = 0, lo = 0, dl, dh, t;
        for (int i = 0; i < 3; i++) begin
            dl = d[i] & 64'hFFFF;
            dh = (d[i] - dl) / 65536;
            hi += n[i] * dh;
            lo += n[i] * dl;
        end
        if (hi >= (64'sd1 <<< 48)) return 1;
        if (hi <= -(64'sd1 <<< 48)) return -1;
        t = hi * 65536 + lo;
        return t > 0 ? 1 : (t < 0 ? -1 : 0);
    endfunction

    // unit normal of the face closed by corner p4
    function automatic t_normal face_normal(longint p4[3], longint oldn[3]);
        t_normal r;
        longint raw[3], dx[3], dy[3], c[3], n[3], d[3];
        longint m = 0, len, q;
        longint unsigned sum = 0;
        int s = 0;
        logic [2:0] md = (cfg_mode > qfno_pkg::MODE_PREV) ? qfno_pkg::MODE_PLAIN : cfg_mode;
        if (md == qfno_pkg::MODE_SPH) begin
            for (int i = 0; i < 3; i++)
                raw[i] = corners[0][i] + corners[1][i] + corners[2][i] + p4[i]
                         - 4 * cfg_ref[i];
        end else begin
            for (int i = 0; i < 3; i++) begin
                dx[i] = corners[1][i] - corners[0][i] + corners[2][i] - p4[i];
                dy[i] = p4[i] - corners[0][i] + corners[2][i] - corners[1][i];
                if (absl(dx[i]) > m) m = absl(dx[i]);
                if (absl(dy[i]) > m) m = absl(dy[i]);
            end
            while (m >= (64'sd1 <<< 30)) begin
                for (int i = 0; i < 3; i++) begin
                    dx[i] = trunc_shr(dx[i], 1);
                    dy[i] = trunc_shr(dy[i], 1);
                end
                m >>>= 1;
            end
            raw[0] = dx[1] * dy[2] - dx[2] * dy[1];
            raw[1] = dx[2] * dy[0] - dx[0] * dy[2];
            raw[2] = dx[0] * dy[1] - dx[1] * dy[0];
        end
        m = 0;
        for (int i = 0; i < 3; i++) if (absl(raw[i]) > m) m = absl(raw[i]);
        r.degen = (m == 0);
        if (r.degen) begin
            r.nx = '0; r.ny = '0; r.nz = '0;
            return r;
        end
        // bring the largest magnitude into [2^30, 2^31)
        if (m >= (64'sd1 <<< 31)) begin
            while ((m >>> s) >= (64'sd1 <<< 31)) s++;
            for (int i = 0; i < 3; i++) c[i] = trunc_shr(raw[i], s);
        end else begin
            while ((m <<< s) < (64'sd1 <<< 30)) s++;
            for (int i = 0; i < 3; i++) c[i] = raw[i] <<< s;
        end
        for (int i = 0; i < 3; i++) sum += longint'(c[i] * c[i]);
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((absl(c[i]) <<< qfno_pkg::NORM_FRAC) + len / 2) / len;
            if (q > (64'sd1 <<< qfno_pkg::NORM_FRAC)) q = 64'sd1 <<< qfno_pkg::NORM_FRAC;
            n[i] = c[i] < 0 ? -q : q;
        end
        if (md >= qfno_pkg::MODE_EXT) begin
            for (int i = 0; i < 3; i++)
                d[i] = (md == qfno_pkg::MODE_EXT) ? corners[0][i] - cfg_ref[i] :
                       (md == qfno_pkg::MODE_DIR) ? cfg_ref[i] : oldn[i];
            if (dot_sign(n, d) < 0)
                for (int i = 0; i < 3; i++) n[i] = -n[i];
        end
        r.nx = qfno_pkg::NORM_W'(n[0]);
        r.ny = qfno_pkg::NORM_W'(n[1]);
        r.nz = qfno_pkg::NORM_W'(n[2]);
        return r;
    endfunction

    // APB register write: setup then access
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr   <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            qfno_pkg::REG_MODE:  cfg_mode = val[2:0];
            qfno_pkg::REG_REF_X: cfg_ref[0] = longint'($signed(val[15:0]));
            qfno_pkg::REG_REF_Y: cfg_ref[1] = longint'($signed(val[15:0]));
            qfno_pkg::REG_REF_Z: cfg_ref[2] = longint'($signed(val[15:0]));
            default: ;
        endcase
    endtask

    task automatic set_config(logic [2:0] md, logic [15:0] rx, logic [15:0] ry,
                              logic [15:0] rz);
        write_reg(qfno_pkg::REG_MODE, {29'd0, md});
        write_reg(qfno_pkg::REG_REF_X, {16'd0, rx});
        write_reg(qfno_pkg::REG_REF_Y, {16'd0, ry});
        write_reg(qfno_pkg::REG_REF_Z, {16'd0, rz});
    endtask

    // send one corner item; predicts the face result on the closing corner
    // s_tvalid stays high into the next item when no gap follows
    task automatic send_corner(logic [1:0] crn, logic [15:0] x, logic [15:0] y,
                               logic [15:0] z, logic [15:0] ox, logic [15:0] oy,
                               logic [15:0] oz);
        longint p[3], o[3];
        int unsigned gap;
        p[0] = $signed(x); p[1] = $signed(y); p[2] = $signed(z);
        o[0] = $signed(ox); o[1] = $signed(oy); o[2] = $signed(oz);
        // never close a face over a corner slot that was never written
        if (crn == qfno_pkg::CORNER_LAST &&
            !(corner_seen[0] && corner_seen[1] && corner_seen[2]))
            return;
        gap = (gap_max > 0 && $urandom_range(3, 0) == 0) ? $urandom_range(gap_max, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= crn;
        s_tdata  <= {oz, oy, ox, z, y, x};
        do @(posedge i_clk); while (!s_tready);
        if (crn == qfno_pkg::CORNER_LAST) begin
            pending_normals.push_back(face_normal(p, o));
        end else begin
            for (int i = 0; i < 3; i++) corners[crn][i] = p[i];
            corner_seen[crn] = 1'b1;
        end
    endtask

    function automatic logic [15:0] rand_old();
        return 16'($signed($urandom_range(32768, 0)) - 16384);
    endfunction

    task automatic send_face(logic [15:0] c[4][3]);
        logic [15:0] ox = rand_old(), oy = rand_old(), oz = rand_old();
        for (int k = 0; k < 4; k++)
            send_corner(2'(k), c[k][0], c[k][1], c[k][2], ox, oy, oz);
    endtask

    // stop sending, wait until every expected normal has been checked, let the back end drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_normal e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_normals.size() == 0) begin
                $error("normal item with no face pending");
                failed = 1'b1;
            end else begin
                e = pending_normals.pop_front();
                if (m_tdata[15:0] !== e.nx) begin
                    $error("normal_x expected %0d got %0d", e.nx, $signed(m_tdata[15:0]));
                    failed = 1'b1;
                end
                if (m_tdata[31:16] !== e.ny) begin
                    $error("normal_y expected %0d got %0d", e.ny, $signed(m_tdata[31:16]));
                    failed = 1'b1;
                end
                if (m_tdata[47:32] !== e.nz) begin
                    $error("normal_z expected %0d got %0d", e.nz, $signed(m_tdata[47:32]));
                    failed = 1'b1;
                end
                if (m_tuser[0] !== e.degen) begin
                    $error("degenerate expected %0d got %0d", e.degen, m_tuser[0]);
                    failed = 1'b1;
                end
            end
        end
    end

    // receiver stall pattern: runs of ready and not-ready
    initial begin
        int unsigned run;
        forever begin
            run = $urandom_range(20, 1);
            m_tready <= ($urandom_range(99, 0) >= stall_pct);
            repeat (run) @(posedge i_clk);
        end
    end

    // run limit: the worst-case face time plus stalls, taken several times
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000) begin
            $display("quad_face_normal_orient_top verification failed");
            $finish;
        end
    end

    task automatic test_extremes();
        logic [15:0] f[4][3];
        // flat unit square in z=0
        f = '{'{16'h0000, 16'h0000, 16'h0000}, '{16'h0100, 16'h0000, 16'h0000},
              '{16'h0100, 16'h0100, 16'h0000}, '{16'h0000, 16'h0100, 16'h0000}};
        send_face(f);
        // all corners equal: degenerate
        f = '{'{16'h1234, 16'h1234, 16'h1234}, '{16'h1234, 16'h1234, 16'h1234},
              '{16'h1234, 16'h1234, 16'h1234}, '{16'h1234, 16'h1234, 16'h1234}};
        send_face(f);
        // coordinate extremes
        f = '{'{16'h8000, 16'h8000, 16'h8000}, '{16'h7FFF, 16'h8000, 16'h7FFF},
              '{16'h7FFF, 16'h7FFF, 16'h8000}, '{16'h8000, 16'h7FFF, 16'hFFFF}};
        send_face(f);
        f = '{'{16'h7FFF, 16'h0000, 16'h8000}, '{16'h8000, 16'h7FFF, 16'h0000},
              '{16'h0000, 16'h8000, 16'h7FFF}, '{16'hFFFF, 16'h0001, 16'h7FFF}};
        send_face(f);
        // reused corners: close twice, restore a corner out of order
        send_corner(qfno_pkg::CORNER_LAST, 16'h0300, 16'h0010, 16'hFF00,
                    16'h4000, 16'h0000, 16'h0000);
        send_corner(2'd1, 16'h0200, 16'hFE00, 16'h0100, 16'h0, 16'h0, 16'h0);
        send_corner(qfno_pkg::CORNER_LAST, 16'h0001, 16'h0002, 16'h0003,
                    16'hC000, 16'h4000, 16'h0);
    endtask

    task automatic test_modes();
        logic [15:0] f[4][3];
        for (int md = 0; md < 8; md++) begin
            drain();
            set_config(3'(md), 16'(md * 16'h1111), 16'h8000 + 16'(md), 16'h7FFF - 16'(md));
            f = '{'{16'h0010, 16'h0020, 16'h0030}, '{16'h0110, 16'h0020, 16'h0030},
                  '{16'h0110, 16'h0120, 16'h0050}, '{16'h0010, 16'h0120, 16'h0030}};
            send_face(f);
            send_corner(qfno_pkg::CORNER_LAST, 16'h0010, 16'h0120, 16'h0030,
                        16'hC000, 16'hC000, 16'hC000);
            send_corner(qfno_pkg::CORNER_LAST, 16'h0010, 16'h0120, 16'h0030,
                        16'h0, 16'h0, 16'h0);
        end
    endtask

    function automatic logic [15:0] rand_coord(int scale);
        case (scale)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(1024, 0)) - 512);
            default: return 16'($signed($urandom_range(8, 0)) - 4);
        endcase
    endfunction

    task automatic test_random(int faces);
        logic [15:0] f[4][3];
        int scale;
        for (int n = 0; n < faces; n++) begin
            if (n % 60 == 0) begin
                drain();
                set_config(3'($urandom_range(7, 0)), 16'($urandom), 16'($urandom),
                           16'($urandom));
                gap_max   = $urandom_range(2, 0) == 0 ? 0 : $urandom_range(30, 1);
                stall_pct = $urandom_range(70, 0);
            end
            scale = $urandom_range(2, 0);
            if ($urandom_range(9, 0) == 0) begin
                // noise: one stray corner, any index
                send_corner(2'($urandom), rand_coord(scale), rand_coord(scale),
                            rand_coord(scale), rand_old(), rand_old(), rand_old());
            end else begin
                for (int k = 0; k < 4; k++)
                    for (int j = 0; j < 3; j++) f[k][j] = rand_coord(scale);
                if ($urandom_range(15, 0) == 0) f[3] = f[1];
                send_face(f);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 3; i++) begin
            cfg_ref[i] = 0; corner_seen[i] = 1'b0;
            for (int j = 0; j < 3; j++) corners[i][j] = 0;
        end
        cfg_mode = qfno_pkg::MODE_PLAIN;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_modes();
        test_random(375);
        drain();
        if (!failed)
            $display("quad_face_normal_orient_top verification clean");
        else
            $display("quad_face_normal_orient_top verification failed");
        $finish;
    end
endmodule
`default_nettype wire
